FILE: src/mvt_pkg.sv
// Shared types and constants of the 4x4 matrix-vector transform engine.
package mvt_pkg;

  localparam int LANE_W = 32;
  localparam int DIM    = 4;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_XFORM = 1'b1
  } mode_e;

  // Per-stage advance strobes of the dot-product pipeline.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

FILE: src/mvt_in_if.sv
// Input request channel: mode, row index and four signed lanes.
interface mvt_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [1:0]  row_index;
  logic [31:0] lane_0;
  logic [31:0] lane_1;
  logic [31:0] lane_2;
  logic [31:0] lane_3;

  modport source (
    output valid, mode, row_index, lane_0, lane_1, lane_2, lane_3,
    input  ready
  );
  modport sink (
    input  valid, mode, row_index, lane_0, lane_1, lane_2, lane_3,
    output ready
  );
endinterface

FILE: src/mvt_out_if.sv
// Result channel: the four transformed vector components.
interface mvt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic [31:0] out_w;

  modport source (
    output valid, out_x, out_y, out_z, out_w,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, out_w,
    output ready
  );
endinterface

FILE: src/mvt_matrix.sv
// Matrix register file: 4x4 elements, identity after reset, one row written per load.
module mvt_matrix #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [1:0]                   row_i,
  input  logic signed [ELEM_WIDTH-1:0] data_i [4],
  output logic signed [ELEM_WIDTH-1:0] mat_o  [4][4]
);
  import mvt_pkg::*;

  localparam logic [ELEM_WIDTH-1:0] ElemMax = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  // Clip the diagonal one to the largest element when it does not fit.
  localparam logic [ELEM_WIDTH-1:0] One =
    (FRAC_BITS <= ELEM_WIDTH - 2) ? ELEM_WIDTH'(64'd1 << FRAC_BITS) : ElemMax;

  logic signed [ELEM_WIDTH-1:0] mat_q [4][4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          mat_q[r][c] <= (r == c) ? One : '0;
        end
      end
    end else if (we_i) begin
      for (int c = 0; c < DIM; c++) begin
        mat_q[row_i][c] <= data_i[c];
      end
    end
  end

  assign mat_o = mat_q;

endmodule

FILE: src/mvt_dot_lane.sv
// One row lane: multiply, pair add, final add with rounding, shift and saturate.
module mvt_dot_lane #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk_i,
  input  mvt_pkg::stage_en_t                  en_i,
  input  logic signed [ELEM_WIDTH-1:0]        row_i [4],
  input  logic signed [ELEM_WIDTH-1:0]        vec_i [4],
  output logic signed [mvt_pkg::LANE_W-1:0]   dot_o
);
  import mvt_pkg::*;

  localparam int PW = 2 * ELEM_WIDTH;
  localparam int SW = PW + 3;
  localparam logic signed [SW-1:0] Rnd  = SW'((65'd1 << FRAC_BITS) >> 1);
  localparam logic signed [SW-1:0] MaxV = SW'({1'b0, {(ELEM_WIDTH-1){1'b1}}});
  localparam logic signed [SW-1:0] MinV = ~MaxV;

  logic signed [PW-1:0]         prod_d [4];
  logic signed [PW-1:0]         prod_q [4];
  logic signed [PW:0]           pair_d [2];
  logic signed [PW:0]           pair_q [2];
  logic signed [SW-1:0]         sum_d;
  logic signed [SW-1:0]         sum_q;
  logic signed [SW-1:0]         shifted;
  logic signed [ELEM_WIDTH-1:0] res;
  logic signed [LANE_W-1:0]     dot_d;
  logic signed [LANE_W-1:0]     dot_q;

  always_comb begin
    for (int c = 0; c < DIM; c++) begin
      prod_d[c] = PW'(row_i[c]) * PW'(vec_i[c]);
    end
    for (int k = 0; k < 2; k++) begin
      pair_d[k] = (PW+1)'(prod_q[2*k]) + (PW+1)'(prod_q[2*k+1]);
    end
    sum_d = SW'(pair_q[0]) + SW'(pair_q[1]) + Rnd;
  end

  // Round half up is floor of (sum + half); saturate after the shift.
  always_comb begin
    shifted = sum_q >>> FRAC_BITS;
    if (shifted > MaxV) begin
      res = ELEM_WIDTH'(MaxV);
    end else if (shifted < MinV) begin
      res = ELEM_WIDTH'(MinV);
    end else begin
      res = ELEM_WIDTH'(shifted);
    end
    dot_d = LANE_W'(res);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      for (int c = 0; c < DIM; c++) begin
        prod_q[c] <= prod_d[c];
      end
    end
    if (en_i.s2) begin
      for (int k = 0; k < 2; k++) begin
        pair_q[k] <= pair_d[k];
      end
    end
    if (en_i.s3) begin
      sum_q <= sum_d;
    end
    if (en_i.s4) begin
      dot_q <= dot_d;
    end
  end

  assign dot_o = dot_q;

endmodule

FILE: src/matrix4_vector_transform.sv
// Top level of the 4x4 matrix times 4-vector transform engine.
// Accepts one request per cycle while the input is ready. A load request (mode 0) writes
// one matrix row in the cycle it is accepted and gives no result; every transform
// accepted afterwards sees it. A transform request (mode 1) gives one result, and a new
// transform can follow every cycle when the output is not stalled. The four stages are:
// 16 parallel signed multiplies of up to 32x32 bits, pair adds, final add with the
// rounding half, then arithmetic shift by FRAC_BITS with saturation to ELEM_WIDTH bits;
// the multiplier stage sets the clock. The matrix is the identity after reset.
module matrix4_vector_transform #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mvt_in_if.sink   in_i,
  mvt_out_if.source out_o
);
  import mvt_pkg::*;

  logic                         acc;
  logic                         acc_load;
  logic                         acc_xform;
  logic [3:0]                   v_q;
  logic [3:0]                   v_d;
  logic [3:0]                   rdy;
  stage_en_t                    en;
  logic signed [ELEM_WIDTH-1:0] vec  [4];
  logic signed [ELEM_WIDTH-1:0] mat  [4][4];
  logic signed [LANE_W-1:0]     dot  [4];

  assign vec[0] = $signed(in_i.lane_0[ELEM_WIDTH-1:0]);
  assign vec[1] = $signed(in_i.lane_1[ELEM_WIDTH-1:0]);
  assign vec[2] = $signed(in_i.lane_2[ELEM_WIDTH-1:0]);
  assign vec[3] = $signed(in_i.lane_3[ELEM_WIDTH-1:0]);

  // A stage advances when it is empty or the next one advances.
  always_comb begin
    rdy[3] = !v_q[3] || out_o.ready;
    for (int k = 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign en.s1 = rdy[0];
  assign en.s2 = rdy[1];
  assign en.s3 = rdy[2];
  assign en.s4 = rdy[3];

  assign in_i.ready = rdy[0];
  assign acc        = in_i.valid && in_i.ready;
  assign acc_load   = acc && (in_i.mode == MODE_LOAD);
  assign acc_xform  = acc && (in_i.mode == MODE_XFORM);

  always_comb begin
    v_d = v_q;
    if (rdy[0]) begin
      v_d[0] = in_i.valid && (in_i.mode == MODE_XFORM);
    end
    for (int k = 1; k < 4; k++) begin
      if (rdy[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  mvt_matrix #(
    .ELEM_WIDTH (ELEM_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_matrix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (acc_load),
    .row_i  (in_i.row_index),
    .data_i (vec),
    .mat_o  (mat)
  );

  for (genvar r = 0; r < DIM; r++) begin : g_lane
    mvt_dot_lane #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .row_i (mat[r]),
      .vec_i (vec),
      .dot_o (dot[r])
    );
  end

  assign out_o.valid = v_q[3];
  assign out_o.out_x = dot[0];
  assign out_o.out_y = dot[1];
  assign out_o.out_z = dot[2];
  assign out_o.out_w = dot[3];

`ifndef SYNTHESIS
  // A row load never enters the dot-product pipeline.
  a_load_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_load |=> !v_q[0])
    else $error("row load entered the pipeline");

  // Input backpressure only when every stage holds a transform.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v_q == 4'b1111))
    else $error("input stalled with an empty stage");

  // With the output taking every result, an accepted transform reaches the output after every stage.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_xform ##1 out_o.ready ##1 out_o.ready ##1 out_o.ready |=> out_o.valid)
    else $error("transform result missing after pipeline latency");
`endif

endmodule
